// ===== hdl/byte_pattern_match_finder_defines.svh =====
// assertion macros for the byte pattern match finder
`ifndef BYTE_PATTERN_MATCH_FINDER_DEFINES_SVH
`define BYTE_PATTERN_MATCH_FINDER_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define BPMF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bpmf assertion failed");
// condition that must hold in the cycle after a trigger
`define BPMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpmf assertion failed");
`else
`define BPMF_ASSERT(lbl, clk, rst_n, prop)
`define BPMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/bpmf_pkg.sv =====
`default_nettype none

package bpmf_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_TEXT    = 65536;
    localparam int NUM_CELLS   = MAX_PATTERN - 1;
    localparam int LEN_W       = 5;
    localparam int POS_W       = 16;
    localparam int SEEN_W      = $clog2(MAX_TEXT + 1);
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_PATTERN_LOW    = 2'd1,
        CFG_PATTERN_HIGH   = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_start;
        logic             end_of_text;
        logic             count_overflow;
    } t_out_beat;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    // pattern byte idx out of the two 64-bit pattern registers
    function automatic logic [7:0] pattern_at(input logic [63:0] lo, input logic [63:0] hi,
                                              input logic [IDX_W-1:0] idx);
        logic [127:0] all;
        all = {hi, lo};
        return all[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bpmf_cell.sv =====
`default_nettype none

module bpmf_cell (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  bpmf_pkg::t_cell_ctrl   i_ctrl,
    input  wire  [7:0]             i_byte,
    input  wire  [7:0]             i_pat_byte,
    input  wire                    i_used,
    output logic [7:0]             o_byte,
    output logic                   o_hit
);
    import bpmf_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.shift) begin
            n_byte = i_ctrl.clear ? 8'h00 : i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'h00;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;
    // unused positions never block a match
    assign o_hit  = !i_used || (r_byte == i_pat_byte);

endmodule

`default_nettype wire

// ===== hdl/byte_pattern_match_finder.sv =====
// byte pattern match finder
// input channel: one text byte per beat (i_in_valid / o_in_stall), last_byte
//   marks the final byte of a text
// output channel: one result beat (o_out_valid / i_out_stall) for every byte
//   that ends an occurrence of the pattern, and always one for a text's last
//   byte; match_start is the zero-based index of the occurrence's first byte
// config: i_cfg_we / i_cfg_index / i_cfg_data write pattern_length (index 0),
//   pattern bytes 0..7 (index 1) and 8..15 (index 2); write only while idle
// latency: a result appears one cycle after its byte is accepted
// throughput: one byte per cycle; a row of 15 window cells shifts the text
//   along and each compares its byte against its pattern byte in parallel
// stall: the single output register holds a waiting result; a new byte is
//   taken whenever that register is empty or being drained this cycle
// reset: window, byte count and overflow flag clear, pattern length 1, pattern
//   bytes zero; no clearing sweep
// texts longer than 65536 bytes saturate the count, set count_overflow and
//   report no further matches
`default_nettype none
`include "byte_pattern_match_finder_defines.svh"

module byte_pattern_match_finder (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  bpmf_pkg::t_in_beat                   i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output bpmf_pkg::t_out_beat                  o_out_data,
    input  wire                                  i_cfg_we,
    input  wire  [bpmf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [bpmf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bpmf_pkg::*;

    // configuration registers
    logic [LEN_W-1:0]      r_len;
    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;

    // text position state
    logic [SEEN_W-1:0]     r_seen;
    logic [SEEN_W-1:0]     n_seen;
    logic                  r_ovf;
    logic                  n_ovf;

    // output register
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out_beat             r_out;
    t_out_beat             n_out;

    logic                  w_accept;
    logic [LEN_W-1:0]      w_len;
    logic                  w_countable;
    logic                  w_enough;
    logic                  w_cur_hit;
    logic                  w_match;
    logic                  w_produce;
    logic                  w_ovf_now;
    logic [SEEN_W-1:0]     w_start;
    t_cell_ctrl            w_ctrl;

    logic [7:0]            w_win     [NUM_CELLS];
    logic [7:0]            w_cell_in [NUM_CELLS];
    logic [7:0]            w_cell_pat[NUM_CELLS];
    logic [NUM_CELLS-1:0]  w_cell_used;
    logic [NUM_CELLS-1:0]  w_cell_hit;

    // config writes; out-of-list indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_W'(1);
            r_pat_lo <= '0;
            r_pat_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LENGTH: r_len    <= i_cfg_data[LEN_W-1:0];
                CFG_PATTERN_LOW:    r_pat_lo <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_hi <= i_cfg_data;
                default:            ;
            endcase
        end
    end

    // clamp length to 1..MAX_PATTERN
    always_comb begin
        if (r_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            w_len = LEN_W'(MAX_PATTERN);
        end else begin
            w_len = r_len;
        end
    end

    assign w_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;

    assign w_ctrl.shift = w_accept;
    assign w_ctrl.clear = w_accept && i_in_data.last_byte;

    // the newest byte lines up with the pattern's last byte
    assign w_cur_hit = (i_in_data.text_byte ==
                        pattern_at(r_pat_lo, r_pat_hi, IDX_W'(w_len - LEN_W'(1))));

    // window cells: cell k holds the byte k+1 positions back
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        logic [LEN_W-1:0] w_diff;

        assign w_diff           = w_len - LEN_W'(k + 2);
        assign w_cell_used[k]   = LEN_W'(k + 1) < w_len;
        assign w_cell_pat[k]    = pattern_at(r_pat_lo, r_pat_hi, w_diff[IDX_W-1:0]);

        if (k == 0) begin : g_head
            assign w_cell_in[k] = i_in_data.text_byte;
        end else begin : g_link
            assign w_cell_in[k] = w_win[k-1];
        end

        bpmf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_byte     (w_cell_in[k]),
            .i_pat_byte (w_cell_pat[k]),
            .i_used     (w_cell_used[k]),
            .o_byte     (w_win[k]),
            .o_hit      (w_cell_hit[k])
        );
    end

    // count saturates at MAX_TEXT
    assign w_countable = (r_seen < SEEN_W'(MAX_TEXT));
    assign w_enough    = (r_seen + SEEN_W'(1)) >= SEEN_W'(w_len);
    assign w_match     = w_countable && w_enough && w_cur_hit && (&w_cell_hit);
    assign w_start     = r_seen + SEEN_W'(1) - SEEN_W'(w_len);
    assign w_ovf_now   = r_ovf || !w_countable;
    assign w_produce   = w_match || i_in_data.last_byte;

    always_comb begin
        n_seen = r_seen;
        n_ovf  = r_ovf;
        if (w_accept) begin
            if (i_in_data.last_byte) begin
                n_seen = '0;
                n_ovf  = 1'b0;
            end else begin
                n_ovf = w_ovf_now;
                if (w_countable) begin
                    n_seen = r_seen + SEEN_W'(1);
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_accept && w_produce) begin
            n_out_valid          = 1'b1;
            n_out.found          = w_match;
            n_out.match_start    = w_match ? w_start[POS_W-1:0] : '0;
            n_out.end_of_text    = i_in_data.last_byte;
            n_out.count_overflow = w_ovf_now;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen      <= n_seen;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a result without a match only closes a text
    `BPMF_ASSERT(a_nomatch_only_at_end, i_clk, i_rst_n,
        !(o_out_valid && !o_out_data.found) || o_out_data.end_of_text)
    // no match is reported once the count has overflowed
    `BPMF_ASSERT(a_no_match_after_ovf, i_clk, i_rst_n,
        !(o_out_valid && o_out_data.found) || !o_out_data.count_overflow)
    // count never passes the saturation point
    `BPMF_ASSERT(a_seen_bounded, i_clk, i_rst_n, r_seen <= SEEN_W'(MAX_TEXT))
    // last byte restarts position and overflow
    `BPMF_ASSERT_NEXT(a_restart_after_last, i_clk, i_rst_n,
        w_accept && i_in_data.last_byte, r_seen == '0 && !r_ovf)

endmodule

`default_nettype wire

// ===== sim/tb_byte_pattern_match_finder.sv =====
module tb_byte_pattern_match_finder;
    timeunit 1ns;
    timeprecision 1ps;

    import bpmf_pkg::*;

    localparam int RANDOM_ITEMS   = 1800;
    localparam int WATCHDOG_LIMIT = 1000;
    // cycles allowed for a byte that gives no result to leave the block
    localparam int SETTLE_CYCLES  = 3;

    // one row of the directed part: either a register write or a text byte
    typedef struct {
        bit          is_cfg;
        t_cfg_index  idx;
        logic [63:0] val;
        t_in_beat    beat;
        bit          typed;
        t_out_beat   res;
    } t_stim_row;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_beat              in_beat   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_cfg_index            cfg_index = CFG_PATTERN_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_beat             o_out_data;

    // shadow of the block: configuration registers
    logic [LEN_W-1:0]      cfg_len = 5'd1;
    logic [63:0]           cfg_lo  = '0;
    logic [63:0]           cfg_hi  = '0;
    // shadow of the block: text state
    logic [7:0]            window_bytes [NUM_CELLS];
    logic [SEEN_W-1:0]     seen_count    = '0;
    logic                  overflow_flag = 1'b0;

    t_out_beat             awaited_results [$];
    t_stim_row             directed_rows [$];
    int                    errors         = 0;
    int                    stalled_cycles = 0;
    // when set, neither side inserts gaps
    bit                    quiet          = 1'b0;

    byte_pattern_match_finder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // length register as the block uses it: 0 acts as 1, above 16 acts as 16
    function automatic int unsigned active_length(input logic [LEN_W-1:0] l);
        if (l == 0)
            return 1;
        if (l > MAX_PATTERN)
            return MAX_PATTERN;
        return l;
    endfunction

    // advance the shadow text state by one byte; returns 1 when a result beat is due
    function automatic bit find_match(input t_in_beat beat, output t_out_beat res);
        int unsigned       len;
        bit                hit;
        logic [127:0]      pat;
        logic [7:0]        t;
        logic [SEEN_W-1:0] start;
        len   = active_length(cfg_len);
        pat   = {cfg_hi, cfg_lo};
        hit   = 1'b0;
        start = '0;
        if (seen_count < SEEN_W'(MAX_TEXT)) begin
            // too few bytes of this text: no occurrence can end here yet
            if (int'(seen_count) + 1 >= len) begin
                hit = 1'b1;
                for (int d = 0; d < len; d++) begin
                    if (d == 0)
                        t = beat.text_byte;
                    else
                        t = window_bytes[d-1];
                    if (t != pat[8*(len-1-d) +: 8])
                        hit = 1'b0;
                end
                if (hit)
                    start = seen_count + 1'b1 - SEEN_W'(len);
            end
            seen_count = seen_count + 1'b1;
        end else begin
            // text too long: count saturates, matches are dropped
            overflow_flag = 1'b1;
        end
        for (int d = NUM_CELLS - 1; d > 0; d--)
            window_bytes[d] = window_bytes[d-1];
        window_bytes[0] = beat.text_byte;

        res.found          = hit;
        res.match_start    = hit ? start[POS_W-1:0] : '0;
        res.end_of_text    = beat.last_byte;
        res.count_overflow = overflow_flag;

        // last byte: next text starts from a clean window and count
        if (beat.last_byte) begin
            for (int d = 0; d < NUM_CELLS; d++)
                window_bytes[d] = 8'h00;
            seen_count    = '0;
            overflow_flag = 1'b0;
        end
        return hit || beat.last_byte;
    endfunction

    // a row with every field cleared
    function automatic t_stim_row blank_row();
        t_stim_row row;
        row.is_cfg = 1'b0;
        row.idx    = CFG_PATTERN_LENGTH;
        row.val    = '0;
        row.beat   = '0;
        row.typed  = 1'b0;
        row.res    = '0;
        return row;
    endfunction

    function automatic void add_cfg(input t_cfg_index idx, input logic [63:0] val);
        t_stim_row row;
        row        = blank_row();
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic last);
        t_stim_row row;
        row                = blank_row();
        row.beat.text_byte = b;
        row.beat.last_byte = last;
        directed_rows.push_back(row);
    endfunction

    // byte row whose result is written out by hand
    function automatic void add_typed(input logic [7:0] b, input logic last, input logic f,
                                      input logic [POS_W-1:0] s, input logic e,
                                      input logic o);
        t_stim_row row;
        row                    = blank_row();
        row.beat.text_byte     = b;
        row.beat.last_byte     = last;
        row.typed              = 1'b1;
        row.res.found          = f;
        row.res.match_start    = s;
        row.res.end_of_text    = e;
        row.res.count_overflow = o;
        directed_rows.push_back(row);
    endfunction

    // offer one text byte, hold it until taken, then book its result
    task automatic push_byte(input t_in_beat beat, input bit typed, input t_out_beat typed_res);
        int        gap;
        bit        has;
        t_out_beat res;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (o_in_stall)
            @(posedge clk);
        has = find_match(beat, res);
        if (typed) begin
            has = 1'b1;
            res = typed_res;
        end
        if (has)
            awaited_results.push_back(res);
    endtask

    // register write, only once the block has drained
    task automatic write_reg(input t_cfg_index idx, input logic [63:0] val);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_PATTERN_LENGTH: cfg_len = val[LEN_W-1:0];
            CFG_PATTERN_LOW:    cfg_lo  = val;
            CFG_PATTERN_HIGH:   cfg_hi  = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stall per beat, stretches without stall in quiet mode
    initial begin : result_sink
        int n;
        forever begin
            n = quiet ? 0 : $urandom_range(0, 18);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!o_out_valid)
                @(posedge clk);
        end
    end

    // compare every taken result beat with the oldest booked one
    always @(posedge clk) begin : result_check
        t_out_beat want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("result beat with no result awaited: %h", o_out_data);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                if (o_out_data.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_out_data.found);
                    errors++;
                end
                if (o_out_data.match_start !== want.match_start) begin
                    $error("match_start: expected %0d, got %0d",
                           want.match_start, o_out_data.match_start);
                    errors++;
                end
                if (o_out_data.end_of_text !== want.end_of_text) begin
                    $error("end_of_text: expected %0d, got %0d",
                           want.end_of_text, o_out_data.end_of_text);
                    errors++;
                end
                if (o_out_data.count_overflow !== want.count_overflow) begin
                    $error("count_overflow: expected %0d, got %0d",
                           want.count_overflow, o_out_data.count_overflow);
                    errors++;
                end
            end
        end
        // watchdog counts cycles with no beat and no register write
        if ((rst_n && in_valid && !o_in_stall) || (rst_n && o_out_valid && !out_stall) ||
            cfg_we)
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial begin : watchdog
        while (stalled_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("tb_byte_pattern_match_finder failed");
        $finish;
    end

    initial begin : stimulus
        t_stim_row         row;
        t_in_beat          beat;
        logic [7:0]        pat_pick [MAX_PATTERN];
        logic [7:0]        text_q [$];
        logic [7:0]        sym_a;
        logic [7:0]        sym_b;
        logic [LEN_W-1:0]  len_val;
        logic [63:0]       word;
        logic [63:0]       lo;
        logic [63:0]       hi;
        int unsigned       ulen;
        int                sent;
        int                budget;
        int                tlen;
        int                cut;
        bit                two_sym;
        bit                noise;

        for (int d = 0; d < NUM_CELLS; d++)
            window_bytes[d] = 8'h00;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // after reset: length 1, pattern byte zero
        add_typed(8'h00, 1'b0, 1'b1, 16'd0, 1'b0, 1'b0);
        // last byte without a match still gives a result
        add_typed(8'hFF, 1'b1, 1'b0, 16'd0, 1'b1, 1'b0);
        // length 0 acts as 1
        add_cfg(CFG_PATTERN_LENGTH, 64'd0);
        add_typed(8'h00, 1'b1, 1'b1, 16'd0, 1'b1, 1'b0);
        // pattern 00 00 ff: zeroed window must not complete it on the first byte
        add_cfg(CFG_PATTERN_LENGTH, 64'd3);
        add_cfg(CFG_PATTERN_LOW, 64'h0000_0000_00FF_0000);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        // pattern swapped mid-text, new one meets the byte already held
        add_cfg(CFG_PATTERN_LENGTH, 64'd2);
        add_cfg(CFG_PATTERN_LOW, 64'h0000_0000_0000_CDAB);
        add_byte(8'hAB, 1'b0);
        add_cfg(CFG_PATTERN_LOW, 64'h0000_0000_0000_12AB);
        add_byte(8'h12, 1'b1);
        // length 31 acts as 16, all-ones pattern, two overlapping matches
        add_cfg(CFG_PATTERN_LENGTH, 64'd31);
        add_cfg(CFG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        add_cfg(CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 15; i++)
            add_byte(8'hFF, 1'b0);
        add_typed(8'hFF, 1'b0, 1'b1, 16'd0, 1'b0, 1'b0);
        add_typed(8'hFF, 1'b1, 1'b1, 16'd1, 1'b1, 1'b0);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.is_cfg)
                write_reg(row.idx, row.val);
            else
                push_byte(row.beat, row.typed, row.res);
        end

        // ---- random part: segments of one pattern each ----
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0:       len_val = 5'd0;
                1:       len_val = 5'($urandom_range(17, 31));
                2:       len_val = 5'd16;
                3:       len_val = 5'($urandom_range(5, 15));
                default: len_val = 5'($urandom_range(1, 4));
            endcase
            ulen = active_length(len_val);
            // a two-symbol pattern makes partial and overlapping matches common
            two_sym = $urandom_range(0, 1);
            sym_a   = 8'($urandom);
            sym_b   = 8'($urandom);
            for (int k = 0; k < MAX_PATTERN; k++)
                pat_pick[k] = two_sym ? ($urandom_range(0, 1) ? sym_a : sym_b) : 8'($urandom);
            for (int k = 0; k < 8; k++) begin
                lo[8*k +: 8] = pat_pick[k];
                hi[8*k +: 8] = pat_pick[k+8];
            end
            // upper bits of the length write carry random junk
            word          = {$urandom, $urandom};
            word[4:0]     = len_val;
            write_reg(CFG_PATTERN_LENGTH, word);
            write_reg(CFG_PATTERN_LOW, lo);
            write_reg(CFG_PATTERN_HIGH, hi);

            // a segment may end mid-text, so the next pattern lands inside a text
            budget = $urandom_range(40, 160);
            while (budget > 0) begin
                tlen  = $urandom_range(1, 2 * ulen + 24);
                noise = ($urandom_range(0, 7) == 0);
                text_q.delete();
                while (text_q.size() < tlen) begin
                    if (noise) begin
                        text_q.push_back(8'($urandom));
                    end else begin
                        case ($urandom_range(0, 3))
                            0: begin
                                for (int k = 0; k < ulen; k++)
                                    text_q.push_back(pat_pick[k]);
                            end
                            1: begin
                                // broken occurrence: a prefix, which may be the whole pattern
                                cut = $urandom_range(1, ulen);
                                for (int k = 0; k < cut; k++)
                                    text_q.push_back(pat_pick[k]);
                            end
                            2: text_q.push_back(pat_pick[$urandom_range(0, ulen - 1)]);
                            default: text_q.push_back(8'($urandom));
                        endcase
                    end
                end
                for (int i = 0; i < tlen && budget > 0; i++) begin
                    beat.text_byte = text_q[i];
                    beat.last_byte = (i == tlen - 1);
                    push_byte(beat, 1'b0, '0);
                    budget--;
                    sent++;
                end
            end
        end

        // ---- drain and finish ----
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb_byte_pattern_match_finder passed");
        else
            $display("tb_byte_pattern_match_finder failed");
        $finish;
    end

endmodule
